// ===== rtl/mdc_pkg.sv =====
`timescale 1ns / 1ps

package mdc_pkg;

  // default sizing handed to the top level
  localparam int MAX_VERTICES_DEF = 256;
  localparam int DIST_BITS_DEF    = 30;

  // fixed field widths of the ports
  localparam int VTX_W    = 9;
  localparam int WEIGHT_W = 16;
  localparam int LEN_W    = 30;

  // infinity marker before clipping to the distance width
  localparam longint unsigned INF_CONST = 64'd987654321;

  // opcodes of an input transaction
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

endpackage

// ===== rtl/min_directed_cycle_floyd_warshall.sv =====
`timescale 1ns / 1ps

// channel | direction | handshake           | payload
// --------+-----------+---------------------+--------------------------------------------
// in_     | input     | in_valid / in_ready | in_opcode, in_from_vertex, in_to_vertex,
//         |           |                     | in_edge_weight
// out_    | output    | out_valid/out_ready | out_cycle_found, out_cycle_length
// cfg_    | input     | cfg_wr_en, no wait  | cfg_vertex_count
//
// an edge load writes one matrix entry when both vertex numbers are in range.
// a run works through each (k, i) row: it reads d[i][k], checks it and, when it is finite,
// relaxes the row's n entries (one relaxation per cycle through a two-read, one-write matrix
// ram), then drains; the cycle search then scans all vertex pairs, drains and posts the result.
// after the result is posted, and after reset, the matrix is rewritten to its reset
// pattern one entry a cycle, all 65536 entries by default; no transaction is taken
// meanwhile. a result still waiting on out_ready when a later run ends holds the block
// before that run posts its result; edge loads are taken while an earlier result waits.

module min_directed_cycle_floyd_warshall
  import mdc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int DIST_BITS    = DIST_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [VTX_W-1:0]    in_from_vertex,
  input  logic [VTX_W-1:0]    in_to_vertex,
  input  logic [WEIGHT_W-1:0] in_edge_weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_cycle_found,
  output logic [LEN_W-1:0]    out_cycle_length,
  input  logic                cfg_wr_en,
  input  logic [VTX_W-1:0]    cfg_vertex_count
);

  localparam int VB        = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int ADDR_W    = 2 * VB;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam longint unsigned DIST_MASK = (64'd1 << DIST_BITS) - 64'd1;
  localparam longint unsigned INF_VAL   = (DIST_MASK < INF_CONST) ? DIST_MASK : INF_CONST;
  localparam logic [DIST_BITS-1:0] INF  = DIST_BITS'(INF_VAL);

  // sequencer codes
  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_FW_IK    = 4'd2;
  localparam logic [3:0] ST_FW_CHK   = 4'd3;
  localparam logic [3:0] ST_FW_ROW   = 4'd4;
  localparam logic [3:0] ST_FW_DRAIN = 4'd5;
  localparam logic [3:0] ST_CY_SCAN  = 4'd6;
  localparam logic [3:0] ST_CY_DR1   = 4'd7;
  localparam logic [3:0] ST_CY_DR2   = 4'd8;
  localparam logic [3:0] ST_REPORT   = 4'd9;

  logic [3:0]           state_r;
  logic [ADDR_W-1:0]    clr_r;
  logic [VB-1:0]        i_r, j_r, k_r, last_r, pj_r;
  logic [VTX_W-1:0]     vertex_count_r;
  logic [DIST_BITS-1:0] ik_r, best_r, s_r;
  logic                 pv_r, cv_r, sv_r;
  logic                 out_valid_r, out_found_r;
  logic [LEN_W-1:0]     out_len_r;

  logic [DIST_BITS-1:0] mem [MEM_DEPTH];
  logic [DIST_BITS-1:0] rda_r, rdb_r;
  logic [ADDR_W-1:0]    ra, rb, wa;
  logic [DIST_BITS-1:0] wd;
  logic                 we;

  logic                 in_acc;
  logic                 load_ok;
  logic [DIST_BITS-1:0] load_w;
  logic [DIST_BITS:0]   via_sum, cy_sum_full;
  logic [DIST_BITS-1:0] via, cy_sum;
  logic                 relax;
  logic [VB-1:0]        n_last;
  logic                 run_short;
  logic                 best_found;
  logic [63:0]          best_ext;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VTX_W'(2);
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_vertex_count;
    end
  end

  // clamped vertex count, kept as the last index
  always_comb begin
    if (32'(vertex_count_r) > MAX_VERTICES) begin
      n_last = VB'(MAX_VERTICES - 1);
    end else begin
      n_last = VB'(vertex_count_r - VTX_W'(1));
    end
    run_short = (vertex_count_r < VTX_W'(2));
  end

  // edge load checks and weight saturation
  always_comb begin
    load_ok = (in_from_vertex != '0) && (in_to_vertex != '0) &&
              (32'(in_from_vertex) <= MAX_VERTICES) && (32'(in_to_vertex) <= MAX_VERTICES);
    load_w  = (DIST_BITS'(in_edge_weight) >= INF) ? INF : DIST_BITS'(in_edge_weight);
  end

  // relaxation through vertex k, saturating at infinity
  always_comb begin
    via_sum = {1'b0, ik_r} + {1'b0, rdb_r};
    via     = (via_sum >= {1'b0, INF}) ? INF : via_sum[DIST_BITS-1:0];
    relax   = pv_r && (rda_r > via);
  end

  // cycle sum of a pair, saturating at infinity
  always_comb begin
    cy_sum_full = {1'b0, rda_r} + {1'b0, rdb_r};
    cy_sum      = (cy_sum_full >= {1'b0, INF}) ? INF : cy_sum_full[DIST_BITS-1:0];
  end

  // read addresses per phase
  always_comb begin
    case (state_r)
      ST_FW_IK: begin
        ra = {i_r, k_r};
        rb = {k_r, j_r};
      end
      ST_CY_SCAN: begin
        ra = {i_r, j_r};
        rb = {j_r, i_r};
      end
      default: begin
        ra = {i_r, j_r};
        rb = {k_r, j_r};
      end
    endcase
  end

  // write port: clearing pass, edge load or relaxed entry
  always_comb begin
    we = 1'b0;
    wa = clr_r;
    wd = (clr_r[ADDR_W-1:VB] == clr_r[VB-1:0]) ? '0 : INF;
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
    end else if (in_acc && (in_opcode == OP_LOAD)) begin
      we = load_ok;
      wa = {VB'(in_from_vertex - VTX_W'(1)), VB'(in_to_vertex - VTX_W'(1))};
      wd = load_w;
    end else if (relax) begin
      we = 1'b1;
      wa = {i_r, pj_r};
      wd = via;
    end
  end

  // distance matrix ram, two registered reads and one write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_r <= mem[ra];
    rdb_r <= mem[rb];
  end

  // result view of the best cycle
  always_comb begin
    best_found = (best_r < INF);
    best_ext   = 64'(best_r);
  end

  // sequencer and pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      last_r      <= '0;
      pv_r        <= 1'b0;
      cv_r        <= 1'b0;
      sv_r        <= 1'b0;
      best_r      <= INF;
      out_valid_r <= 1'b0;
    end else begin
      pv_r <= (state_r == ST_FW_ROW);
      pj_r <= j_r;
      cv_r <= (state_r == ST_CY_SCAN) && (i_r != j_r);
      sv_r <= cv_r;
      s_r  <= cy_sum;
      if (sv_r && (s_r < best_r)) begin
        best_r <= s_r;
      end
      // the report state handles its own handoff
      if (out_valid_r && out_ready && (state_r != ST_REPORT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + ADDR_W'(1);
          if (clr_r == ADDR_W'(MEM_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && (in_opcode == OP_RUN)) begin
            best_r  <= INF;
            i_r     <= '0;
            j_r     <= '0;
            k_r     <= '0;
            last_r  <= n_last;
            state_r <= run_short ? ST_REPORT : ST_FW_IK;
          end
        end
        ST_FW_IK: begin
          state_r <= ST_FW_CHK;
        end
        ST_FW_CHK: begin
          // an infinite d[i][k] cannot improve the row
          ik_r <= rda_r;
          j_r  <= '0;
          state_r <= (rda_r >= INF) ? ST_FW_DRAIN : ST_FW_ROW;
        end
        ST_FW_ROW: begin
          if (j_r == last_r) begin
            state_r <= ST_FW_DRAIN;
          end else begin
            j_r <= j_r + VB'(1);
          end
        end
        ST_FW_DRAIN: begin
          j_r <= '0;
          if (i_r == last_r) begin
            i_r <= '0;
            if (k_r == last_r) begin
              state_r <= ST_CY_SCAN;
            end else begin
              k_r     <= k_r + VB'(1);
              state_r <= ST_FW_IK;
            end
          end else begin
            i_r     <= i_r + VB'(1);
            state_r <= ST_FW_IK;
          end
        end
        ST_CY_SCAN: begin
          if (j_r == last_r) begin
            j_r <= '0;
            if (i_r == last_r) begin
              state_r <= ST_CY_DR1;
            end else begin
              i_r <= i_r + VB'(1);
            end
          end else begin
            j_r <= j_r + VB'(1);
          end
        end
        ST_CY_DR1: begin
          state_r <= ST_CY_DR2;
        end
        ST_CY_DR2: begin
          state_r <= ST_REPORT;
        end
        ST_REPORT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= best_found;
            out_len_r   <= best_found ? best_ext[LEN_W-1:0] : '0;
            clr_r       <= '0;
            state_r     <= ST_CLEAR;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
          clr_r   <= '0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cycle_found  = out_found_r;
  assign out_cycle_length = out_len_r;

endmodule

// ===== rtl/mdc_checker.sv =====
`timescale 1ns / 1ps

module mdc_checker
  import mdc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_opcode,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_cycle_found,
  input logic [LEN_W-1:0]    out_cycle_length
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cycle_found) &&
    $stable(out_cycle_length))
    else $error("result changed while stalled");

  // no cycle reports a zero length
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cycle_found |-> out_cycle_length == '0)
    else $error("length nonzero without a cycle");

  // a found cycle is always below the infinity marker
  a_found_finite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cycle_found |-> 64'(out_cycle_length) < INF_CONST)
    else $error("found cycle at or above infinity");

  // a run transaction makes the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_RUN) |=> !in_ready)
    else $error("input still ready after a run");

  // an edge load keeps the input open
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_LOAD) |=> in_ready)
    else $error("input closed after an edge load");

endmodule

bind min_directed_cycle_floyd_warshall mdc_checker u_mdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_opcode        (in_opcode),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_cycle_found  (out_cycle_found),
  .out_cycle_length (out_cycle_length)
);
